// ===== rtl/core/ccb_pkg.sv =====
package ccb_pkg;

   // Field widths
   localparam int CHAR_WIDTH  = 8;
   localparam int SHIFT_WIDTH = 6;
   localparam int POS_WIDTH   = 4;
   localparam int CSR_IDX_WIDTH = 2;

   // Shift limits and position ring
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_LIMIT = 6'd32;
   localparam logic [POS_WIDTH-1:0]   POS_LAST    = 4'd9;

   // Character classes: base code and ring size
   localparam logic [CHAR_WIDTH-1:0] CYR_BASE   = 8'hC0;
   localparam logic [6:0]            CYR_SIZE   = 7'd64;
   localparam logic [CHAR_WIDTH-1:0] LAT_BASE   = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] LAT_TOP    = 8'h7A;
   localparam logic [6:0]            LAT_SIZE   = 7'd58;
   localparam logic [CHAR_WIDTH-1:0] PUNCT_BASE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] PUNCT_TOP  = 8'h40;
   localparam logic [6:0]            PUNCT_SIZE = 7'd33;
   localparam logic [CHAR_WIDTH-1:0] YO_UPPER   = 8'hA8;
   localparam logic [CHAR_WIDTH-1:0] YO_LOWER   = 8'hB8;

   // Register map
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DYNAMIC_MODE = 2'd0,
      CSR_DECRYPT      = 2'd1,
      CSR_SHIFT_AMOUNT = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_in;
      logic                  msg_last;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_out;
      logic                  out_last;
   } rsp_type;

   // Word held in the input stage
   typedef struct packed {
      logic [CHAR_WIDTH-1:0]  char_in;
      logic                   msg_last;
      logic [SHIFT_WIDTH-1:0] shift;
   } stage_type;

endpackage

// ===== rtl/core/ccb_position.sv =====
module ccb_position (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            msg_last,
   input  logic                            dynamic_mode,
   input  logic [ccb_pkg::SHIFT_WIDTH-1:0] shift_amount,
   output logic [ccb_pkg::SHIFT_WIDTH-1:0] shift
);
   import ccb_pkg::*;

   logic [POS_WIDTH-1:0] pos_ff;
   logic [POS_WIDTH-1:0] pos_in;

   // Position in message, mod ten; restarts after a last byte
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (msg_last || pos_ff == POS_LAST) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Shift for the byte being accepted; fixed shift saturates at the limit
   always_comb begin
      if (dynamic_mode) begin
         shift = {{(SHIFT_WIDTH-POS_WIDTH){1'b0}}, pos_ff};
      end else if (shift_amount > SHIFT_LIMIT) begin
         shift = SHIFT_LIMIT;
      end else begin
         shift = shift_amount;
      end
   end

endmodule

// ===== rtl/core/ccb_rotate.sv =====
module ccb_rotate (
   input  logic [ccb_pkg::CHAR_WIDTH-1:0]  char_in,
   input  logic [ccb_pkg::SHIFT_WIDTH-1:0] shift,
   input  logic                            decrypt,
   output logic [ccb_pkg::CHAR_WIDTH-1:0]  char_out
);
   import ccb_pkg::*;

   logic                  rotate;
   logic [CHAR_WIDTH-1:0] base;
   logic [6:0]            size;
   logic [CHAR_WIDTH-1:0] diff;
   logic [6:0]            sum;
   logic [6:0]            wrapped;

   // Classify the byte
   always_comb begin
      rotate = 1'b1;
      base   = PUNCT_BASE;
      size   = PUNCT_SIZE;
      if (char_in >= CYR_BASE) begin
         base = CYR_BASE;
         size = CYR_SIZE;
      end else if (char_in >= LAT_BASE && char_in <= LAT_TOP) begin
         base = LAT_BASE;
         size = LAT_SIZE;
      end else if (char_in >= PUNCT_BASE && char_in <= PUNCT_TOP) begin
         base = PUNCT_BASE;
         size = PUNCT_SIZE;
      end else begin
         rotate = 1'b0;
      end
   end

   // Offset in class plus or minus shift, one wrap step (sum < 2 * size)
   always_comb begin
      diff = char_in - base;
      if (decrypt) begin
         sum = {1'b0, diff[5:0]} + size - {1'b0, shift};
      end else begin
         sum = {1'b0, diff[5:0]} + {1'b0, shift};
      end
      if (sum >= size) begin
         wrapped = sum - size;
      end else begin
         wrapped = sum;
      end
   end

   // Select result: swap pair, rotated, or pass-through
   always_comb begin
      if (char_in == YO_UPPER) begin
         char_out = YO_LOWER;
      end else if (char_in == YO_LOWER) begin
         char_out = YO_UPPER;
      end else if (rotate) begin
         char_out = base + {2'b00, wrapped[5:0]};
      end else begin
         char_out = char_in;
      end
   end

endmodule

// ===== rtl/core/caesar_byte_cipher_top.sv =====
// An accepted input word is registered in the input stage, then its result in the result stage, which drives rsp_data.
// Throughput: one word per cycle while rsp_stall is low; the input and result registers form a two-deep pipeline,
// so one more word is taken while a finished result waits on rsp_stall.
// Reset (synchronous, active high) empties both stages, clears the message position
// counter and loads dynamic_mode = 0, decrypt = 0, shift_amount = 1.
module caesar_byte_cipher_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ccb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ccb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccb_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [ccb_pkg::SHIFT_WIDTH-1:0]   csr_wdata
);
   import ccb_pkg::*;

   logic                   dynamic_mode_ff;
   logic                   decrypt_ff;
   logic [SHIFT_WIDTH-1:0] shift_amount_ff;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   stage_type              s1_data_ff;
   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   rsp_type                s2_data_ff;

   logic                   s2_load;
   logic                   s1_load;
   logic                   req_accept;
   logic [SHIFT_WIDTH-1:0] shift;
   logic [CHAR_WIDTH-1:0]  rot_char;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dynamic_mode_ff <= 1'b0;
         decrypt_ff      <= 1'b0;
         shift_amount_ff <= 6'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DYNAMIC_MODE: dynamic_mode_ff <= csr_wdata[0];
            CSR_DECRYPT:      decrypt_ff      <= csr_wdata[0];
            CSR_SHIFT_AMOUNT: shift_amount_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Pipeline flow control
   assign s2_load    = !s2_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   ccb_position u_position (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .msg_last     (req_data.msg_last),
      .dynamic_mode (dynamic_mode_ff),
      .shift_amount (shift_amount_ff),
      .shift        (shift)
   );

   // Input stage
   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff.char_in  <= req_data.char_in;
         s1_data_ff.msg_last <= req_data.msg_last;
         s1_data_ff.shift    <= shift;
      end
   end

   ccb_rotate u_rotate (
      .char_in  (s1_data_ff.char_in),
      .shift    (s1_data_ff.shift),
      .decrypt  (decrypt_ff),
      .char_out (rot_char)
   );

   // Result stage
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_data_ff.char_out <= rot_char;
         s2_data_ff.out_last <= s1_data_ff.msg_last;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

endmodule

// ===== rtl/core/ccb_checker.sv =====
module ccb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ccb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ccb_pkg::rsp_type rsp_data
);
   import ccb_pkg::*;

   // Pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // Swap pair: an accepted upper code comes out as the lower code when the output drains
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.char_in == YO_UPPER) ##1 !rsp_stall
      |=> rsp_valid && rsp_data.char_out == YO_LOWER)
      else $error("swap pair not mapped");

   // Last marker follows its word through the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall
      |=> rsp_valid && rsp_data.out_last == $past(req_data.msg_last, 2))
      else $error("last marker lost or misaligned");

endmodule

bind caesar_byte_cipher_top ccb_checker u_ccb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/caesar_byte_cipher_top_test.sv =====
`timescale 1ns / 100ps

module caesar_byte_cipher_top_test;
   import ccb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 96;
   // index 3 is not mapped; writes to it must change nothing
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [SHIFT_WIDTH-1:0]   csr_wdata = '0;

   // shadow of the block's registers and message position
   logic                   cfg_dynamic = 1'b0;
   logic                   cfg_decrypt = 1'b0;
   logic [SHIFT_WIDTH-1:0] cfg_shift   = 6'd1;
   logic [POS_WIDTH-1:0]   msg_pos     = '0;

   req_type text_q[$];     // words waiting to be sent
   rsp_type cipher_q[$];   // predicted result words, oldest first
   rsp_type want;

   int errors      = 0;
   int cycle_count = 0;
   int send_odds   = 0;    // 1 in send_odds chance of a gap burst, 0 means none
   int stall_odds  = 0;
   int gap_left    = 0;
   int stall_left  = 0;

   caesar_byte_cipher_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // rotate c within the ring [base, base+size)
   function automatic logic [7:0] spin(input logic [7:0] c, input logic [7:0] base,
                                       input int size, input int s, input logic dec);
      int off;
      off = int'(c) - int'(base);
      if (dec) begin
         off = (off + size - s) % size;
      end else begin
         off = (off + s) % size;
      end
      return base + off[7:0];
   endfunction

   // cipher one word and advance the message position
   function automatic rsp_type cipher_word(input req_type w);
      rsp_type r;
      int      s;
      if (cfg_dynamic) begin
         s = int'(msg_pos);
      end else begin
         s = (cfg_shift > SHIFT_LIMIT) ? int'(SHIFT_LIMIT) : int'(cfg_shift);
      end
      r.out_last = w.msg_last;
      if (w.char_in >= CYR_BASE) begin
         r.char_out = spin(w.char_in, CYR_BASE, int'(CYR_SIZE), s, cfg_decrypt);
      end else if (w.char_in == YO_UPPER) begin
         r.char_out = YO_LOWER;
      end else if (w.char_in == YO_LOWER) begin
         r.char_out = YO_UPPER;
      end else if (w.char_in >= LAT_BASE && w.char_in <= LAT_TOP) begin
         r.char_out = spin(w.char_in, LAT_BASE, int'(LAT_SIZE), s, cfg_decrypt);
      end else if (w.char_in >= PUNCT_BASE && w.char_in <= PUNCT_TOP) begin
         r.char_out = spin(w.char_in, PUNCT_BASE, int'(PUNCT_SIZE), s, cfg_decrypt);
      end else begin
         r.char_out = w.char_in;
      end
      if (w.msg_last) begin
         msg_pos = '0;
      end else begin
         msg_pos = (msg_pos == POS_LAST) ? '0 : msg_pos + 1'b1;
      end
      return r;
   endfunction

   // random byte, weighted toward the rings and their edges
   function automatic logic [7:0] pick_char();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 11))
               0: return CYR_BASE;
               1: return 8'hFF;
               2: return LAT_BASE;
               3: return LAT_TOP;
               4: return PUNCT_BASE;
               5: return PUNCT_TOP;
               6: return 8'h1F;
               7: return 8'h7B;
               8: return 8'hBF;
               9: return 8'h00;
               10: return 8'hA7;
               default: return 8'hB9;
            endcase
         end
         1, 2: return 8'($urandom_range(8'hC0, 8'hFF));
         3, 4: return 8'($urandom_range(8'h41, 8'h7A));
         5: return 8'($urandom_range(8'h20, 8'h40));
         6: return $urandom_range(0, 1) ? YO_UPPER : YO_LOWER;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_word(input logic [7:0] c, input logic last);
      req_type w;
      w.char_in  = c;
      w.msg_last = last;
      text_q.push_back(w);
   endtask

   // wait until every word is sent and every result is back
   task automatic settle();
      do @(negedge clock);
      while (text_q.size() != 0 || req_valid || cipher_q.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [SHIFT_WIDTH-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DYNAMIC_MODE: cfg_dynamic = val[0];
         CSR_DECRYPT:      cfg_decrypt = val[0];
         CSR_SHIFT_AMOUNT: cfg_shift   = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // random settings for one phase, registers in a randomly rotated order
   task automatic random_setup();
      int                     start;
      int                     idx;
      logic [SHIFT_WIDTH-1:0] val;
      start = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
         idx = (start + k) % 3;
         if (idx == int'(CSR_SHIFT_AMOUNT)) begin
            case ($urandom_range(0, 5))
               0: val = 6'd0;
               1: val = SHIFT_LIMIT;
               2: val = 6'd33;
               3: val = 6'd63;
               default: val = 6'($urandom_range(0, 63));
            endcase
         end else if ($urandom_range(0, 3) == 0) begin
            val = 6'($urandom_range(0, 63));   // junk in the unused upper bits
         end else begin
            val = 6'($urandom_range(0, 1));
         end
         write_reg(CSR_IDX_WIDTH'(idx), val);
      end
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_UNMAPPED, 6'($urandom_range(0, 63)));
      end
   endtask

   // messages of random length; some run on past the end of the phase
   task automatic queue_messages(input int count);
      int len;
      int sent;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
         for (int i = 0; i < len && sent < count; i++) begin
            push_word(pick_char(), (i == len - 1) && ($urandom_range(0, 7) != 0));
            sent++;
         end
      end
   endtask

   // driver: predicts each accepted word, then loads the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            cipher_q.push_back(cipher_word(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (send_odds != 0 && $urandom_range(0, send_odds - 1) == 0) begin
               gap_left = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
               req_data  <= text_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks result words and applies back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = cipher_q.pop_front();
            if (rsp_data.char_out !== want.char_out) begin
               $display("%0t: char_out expected %h, actual %h",
                        $time, want.char_out, rsp_data.char_out);
               errors++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $display("%0t: out_last expected %b, actual %b",
                        $time, want.out_last, rsp_data.out_last);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: shift 1, encrypt; every class and its edges
      send_odds  = 3;
      stall_odds = 3;
      push_word(8'h00, 1'b0);
      push_word(8'h1F, 1'b0);
      push_word(PUNCT_BASE, 1'b0);
      push_word(PUNCT_TOP, 1'b0);
      push_word(LAT_BASE, 1'b0);
      push_word(LAT_TOP, 1'b0);
      push_word(YO_UPPER, 1'b0);
      push_word(YO_LOWER, 1'b0);
      push_word(CYR_BASE, 1'b0);
      push_word(8'hFF, 1'b1);
      settle();

      // largest legal shift, decrypt: wraps below each ring base
      write_reg(CSR_SHIFT_AMOUNT, SHIFT_LIMIT);
      write_reg(CSR_DECRYPT, 6'd1);
      push_word(PUNCT_BASE, 1'b0);
      push_word(LAT_BASE, 1'b0);
      push_word(CYR_BASE, 1'b1);
      settle();

      // shift beyond the limit saturates
      write_reg(CSR_SHIFT_AMOUNT, 6'd45);
      write_reg(CSR_DECRYPT, 6'd0);
      push_word(PUNCT_TOP, 1'b0);
      push_word(8'hFF, 1'b1);
      settle();

      // dynamic shift over a long message: position wraps after nine
      write_reg(CSR_DYNAMIC_MODE, 6'd1);
      for (int i = 0; i < 11; i++) begin
         push_word(LAT_TOP, 1'b0);
      end
      settle();

      // mode flips mid-message, position keeps counting
      write_reg(CSR_DYNAMIC_MODE, 6'd2);
      push_word(LAT_BASE, 1'b0);
      settle();
      write_reg(CSR_DYNAMIC_MODE, 6'd1);
      push_word(LAT_BASE, 1'b1);
      settle();

      // random phases; the last one runs without idling
      for (int p = 0; p < PHASES; p++) begin
         random_setup();
         case ($urandom_range(0, 2))
            0: send_odds = 0;
            1: send_odds = 4;
            default: send_odds = 16;
         endcase
         case ($urandom_range(0, 2))
            0: stall_odds = 0;
            1: stall_odds = 4;
            default: stall_odds = 16;
         endcase
         if (p == PHASES - 1) begin
            send_odds  = 0;
            stall_odds = 0;
         end
         queue_messages(PHASE_WORDS);
         settle();
      end

      repeat (8) @(posedge clock);
      if (errors == 0 && cipher_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
